// File: design/b85_pkg.sv
// Shared types, constants and tables for the base85 stream codec.
package b85_pkg;

    localparam logic MODE_ENC = 1'b0;
    localparam logic MODE_DEC = 1'b1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CHAR_OFS  = 8'd35;
    localparam logic [7:0] CHAR_SKIP = 8'd92;

    localparam logic [2:0] ENC_GROUP_LAST = 3'd3;
    localparam logic [2:0] DEC_GROUP_LAST = 3'd4;
    localparam logic [2:0] ENC_DIGIT_LAST = 3'd4;
    localparam logic [2:0] DEC_BYTE_LAST  = 3'd3;

    // floor(w / 85) == (w * RECIP) >> RECIP_SHIFT for every 32-bit w
    localparam logic [31:0] RECIP       = 32'd3233857729;
    localparam int          RECIP_SHIFT = 38;
    localparam logic [6:0]  RADIX       = 7'd85;

    typedef enum logic [1:0] {
        OP_ENC,
        OP_DEC,
        OP_ERR
    } op_t;

    typedef struct packed {
        logic [31:0] word;
        op_t         op;
        logic        last;
    } entry_t;

    function automatic logic [31:0] weight_of(input logic [2:0] idx);
        logic [31:0] w;
        case (idx)
            3'd0:    w = 32'd1;
            3'd1:    w = 32'd85;
            3'd2:    w = 32'd7225;
            3'd3:    w = 32'd614125;
            3'd4:    w = 32'd52200625;
            default: w = 32'd0;
        endcase
        return w;
    endfunction

endpackage

// File: design/b85_front.sv
// Input side: mode register, group gathering and job classification.
module b85_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,
    input  logic              s_tlast,
    input  logic              q_full,
    output logic              push,
    output b85_pkg::entry_t   push_entry
);

    logic        mode_reg;
    logic [31:0] word_reg, word_next;
    logic [2:0]  count_reg, count_next;
    logic        accept;
    logic [31:0] enc_word;
    logic [31:0] dec_word;
    logic [8:0]  digit;
    logic [31:0] digit32;
    logic [31:0] prod;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    assign enc_word = word_reg | ({24'b0, s_tdata} << {count_reg[1:0], 3'b000});
    assign digit    = (s_tdata >= b85_pkg::CHAR_SKIP)
                    ? ({1'b0, s_tdata} - {1'b0, b85_pkg::CHAR_OFS} - 9'd1)
                    : ({1'b0, s_tdata} - {1'b0, b85_pkg::CHAR_OFS});
    assign digit32  = {{23{digit[8]}}, digit};
    assign prod     = digit32 * b85_pkg::weight_of(count_reg);
    assign dec_word = word_reg + prod;

    always_comb
    begin
        word_next       = word_reg;
        count_next      = count_reg;
        push            = 1'b0;
        push_entry.word = enc_word;
        push_entry.op   = b85_pkg::OP_ENC;
        push_entry.last = s_tlast;
        if (accept)
        begin
            if (mode_reg == b85_pkg::MODE_ENC)
            begin
                if (count_reg == b85_pkg::ENC_GROUP_LAST || s_tlast)
                begin
                    push       = 1'b1;
                    word_next  = '0;
                    count_next = '0;
                end
                else
                begin
                    word_next  = enc_word;
                    count_next = count_reg + 3'd1;
                end
            end
            else
            begin
                push_entry.word = dec_word;
                if (count_reg == b85_pkg::DEC_GROUP_LAST)
                begin
                    push          = 1'b1;
                    push_entry.op = b85_pkg::OP_DEC;
                    word_next     = '0;
                    count_next    = '0;
                end
                else if (s_tlast)
                begin
                    push          = 1'b1;
                    push_entry.op = b85_pkg::OP_ERR;
                    word_next     = '0;
                    count_next    = '0;
                end
                else
                begin
                    word_next  = dec_word;
                    count_next = count_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= b85_pkg::MODE_ENC;
            word_reg  <= '0;
            count_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            mode_reg  <= cfg_wr_data;
            word_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            word_reg  <= word_next;
            count_reg <= count_next;
        end
    end

endmodule

// File: design/b85_queue.sv
// Short job queue between the front and back parts.
module b85_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  b85_pkg::entry_t   push_entry,
    input  logic              pop,
    output logic              head_valid,
    output b85_pkg::entry_t   head,
    output logic              full
);

    b85_pkg::entry_t                   mem_reg [b85_pkg::QUEUE_DEPTH];
    logic [b85_pkg::QPTR_W-1:0]        wr_ptr_reg, rd_ptr_reg;
    logic [b85_pkg::QCNT_W-1:0]        count_reg;
    logic                              do_push, do_pop;

    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == b85_pkg::QCNT_W'(b85_pkg::QUEUE_DEPTH));
    assign head       = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == b85_pkg::QPTR_W'(b85_pkg::QUEUE_DEPTH - 1))
                            ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == b85_pkg::QPTR_W'(b85_pkg::QUEUE_DEPTH - 1))
                            ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: design/b85_back.sv
// Output side: digit extraction, byte splitting and the output register.
module b85_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  b85_pkg::entry_t   head,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,
    output logic              m_tlast,
    output logic              m_tuser
);

    logic             busy_reg;
    logic [31:0]      word_reg, word_next;
    logic [2:0]       step_reg;
    b85_pkg::op_t     op_reg;
    logic             last_reg;
    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic             out_last_reg;
    logic             out_err_reg;

    logic             adv;
    logic             final_step;
    logic [7:0]       step_byte;
    logic             step_last;
    logic             step_err;
    logic [63:0]      recip_prod;
    logic [6:0]       quot_low;
    logic [13:0]      quot_mul;
    logic [6:0]       rem;
    logic [7:0]       ch_base;
    logic [7:0]       ch;

    assign recip_prod = {32'b0, word_reg} * {32'b0, b85_pkg::RECIP};
    assign quot_low   = recip_prod[b85_pkg::RECIP_SHIFT +: 7];
    assign quot_mul   = quot_low * b85_pkg::RADIX;
    assign rem        = word_reg[6:0] - quot_mul[6:0];
    assign ch_base    = {1'b0, rem} + b85_pkg::CHAR_OFS;
    assign ch         = (ch_base >= b85_pkg::CHAR_SKIP) ? ch_base + 8'd1 : ch_base;

    always_comb
    begin
        word_next  = word_reg;
        step_byte  = 8'd0;
        step_last  = 1'b1;
        step_err   = 1'b0;
        final_step = 1'b1;
        unique case (op_reg)
            b85_pkg::OP_ENC:
            begin
                if (step_reg <= b85_pkg::ENC_DIGIT_LAST)
                begin
                    step_byte  = ch;
                    step_last  = 1'b0;
                    final_step = (step_reg == b85_pkg::ENC_DIGIT_LAST) && !last_reg;
                    word_next  = 32'(recip_prod[63:b85_pkg::RECIP_SHIFT]);
                end
            end
            b85_pkg::OP_DEC:
            begin
                step_byte  = word_reg[7:0];
                final_step = (step_reg == b85_pkg::DEC_BYTE_LAST);
                step_last  = last_reg && final_step;
                word_next  = word_reg >> 8;
            end
            b85_pkg::OP_ERR:
            begin
                step_err = 1'b1;
            end
            default:
            begin
                step_err = 1'b1;
            end
        endcase
    end

    assign adv = busy_reg && (!out_valid_reg || m_tready);
    assign pop = head_valid && (!busy_reg || (adv && final_step));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= '0;
            op_reg        <= b85_pkg::OP_ENC;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
                op_reg   <= head.op;
            end
            else if (adv && final_step)
            begin
                busy_reg <= 1'b0;
            end
            else if (adv)
            begin
                step_reg <= step_reg + 3'd1;
            end

            if (adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            word_reg <= head.word;
            last_reg <= head.last;
        end
        else if (adv)
        begin
            word_reg <= word_next;
        end

        if (adv)
        begin
            out_byte_reg <= step_byte;
            out_last_reg <= step_last;
            out_err_reg  <= step_err;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_err_reg;

endmodule

// File: design/base85_stream_codec.sv
// Base85 stream codec top level: front part, job queue and back part.
// Path of a group: job queue, back part word register, output register.
// Throughput: one input item per cycle unless the queue is full; the back part emits
// one result per cycle unless m_tready stalls; the back paces encode, the input decode.
// Reset: rst_n clears mode to encode, the partial group, the queue and the output register.
module base85_stream_codec (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,  // mode
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // [7:0] data_byte
    input  logic        s_tlast,      // last_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,      // [7:0] out_byte
    output logic        m_tlast,      // out_last
    output logic        m_tuser       // [0] error
);

    logic              q_full;
    logic              push;
    b85_pkg::entry_t   push_entry;
    logic              pop;
    logic              head_valid;
    b85_pkg::entry_t   head;

    b85_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .q_full      (q_full),
        .push        (push),
        .push_entry  (push_entry)
    );

    b85_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head),
        .full       (q_full)
    );

    b85_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule

// File: dv/tb_base85_stream_codec.sv
// Self-checking testbench for the base85 stream codec: directed and random streams in both modes.
module tb_base85_stream_codec;

    localparam int RAND_ITEMS  = 420;
    localparam int SETTLE      = 8;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } feed_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       err;
    } codec_out_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic       cfg_wr_data = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic       m_tuser;

    feed_t      byte_feed_q[$];
    codec_out_t codec_out_q[$];

    logic        cur_mode = b85_pkg::MODE_ENC;
    logic [31:0] grp_word = 32'd0;
    logic [2:0]  grp_cnt = 3'd0;
    logic [31:0] dig_weight = 32'd1;

    logic        s_fire = 1'b0;
    int          burst_left = 0;
    int          gap_left = 0;
    logic [15:0] rx_pat = 16'hffff;
    logic [5:0]  rx_tick = 6'd0;

    int fail_cnt = 0;
    int cycle_cnt = 0;
    int items_seen = 0;
    int results_seen = 0;
    int mode_writes = 0;
    int streams = 0;
    int rnd_items = 0;

    base85_stream_codec u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (fail_cnt < 40)
        begin
            $display("mismatch at result %0d: %s got 0x%0h want 0x%0h",
                     results_seen, what, got, want);
        end
        fail_cnt++;
    endtask

    function automatic logic [7:0] b85_char(input logic [31:0] w);
        logic [31:0] c;
        c = (w % 32'd85) + 32'd35;
        if (c >= 32'd92)
        begin
            c = c + 32'd1;
        end
        return c[7:0];
    endfunction

    function automatic void push_out(input logic [7:0] ch, input logic last, input logic err);
        codec_out_t r;
        r.ch   = ch;
        r.last = last;
        r.err  = err;
        codec_out_q.push_back(r);
    endfunction

    function automatic void clear_group();
        grp_word   = 32'd0;
        grp_cnt    = 3'd0;
        dig_weight = 32'd1;
    endfunction

    function automatic void codec_step(input logic [7:0] b, input logic lst);
        logic [31:0] w;
        logic [31:0] digit;
        if (cur_mode == b85_pkg::MODE_ENC)
        begin
            grp_word = grp_word | ({24'd0, b} << ({3'd0, grp_cnt[1:0]} * 5'd8));
            grp_cnt  = grp_cnt + 3'd1;
            if (grp_cnt >= 3'd4 || lst)
            begin
                w = grp_word;
                for (int i = 0; i < 5; i++)
                begin
                    push_out(b85_char(w), 1'b0, 1'b0);
                    w = w / 32'd85;
                end
                clear_group();
            end
            if (lst)
            begin
                push_out(8'h00, 1'b1, 1'b0);
                clear_group();
            end
        end
        else
        begin
            digit      = (b >= 8'd92) ? {24'd0, b} - 32'd36 : {24'd0, b} - 32'd35;
            grp_word   = grp_word + digit * dig_weight;
            dig_weight = dig_weight * 32'd85;
            grp_cnt    = grp_cnt + 3'd1;
            if (grp_cnt >= 3'd5)
            begin
                w = grp_word;
                push_out(w[7:0], 1'b0, 1'b0);
                push_out(w[15:8], 1'b0, 1'b0);
                push_out(w[23:16], 1'b0, 1'b0);
                push_out(w[31:24], lst, 1'b0);
                clear_group();
            end
            else if (lst)
            begin
                push_out(8'h00, 1'b1, 1'b1);
                clear_group();
            end
        end
    endfunction

    // monitor: check results, track mode writes, predict accepted items
    always @(posedge clk)
    begin : monitor
        codec_out_t got;
        codec_out_t want;
        if (rst_n)
        begin
            s_fire <= s_tvalid && s_tready;
            if (m_tvalid && m_tready)
            begin
                got.ch   = m_tdata;
                got.last = m_tlast;
                got.err  = m_tuser;
                if (codec_out_q.size() == 0)
                begin
                    report_mismatch("unexpected item, out_byte", int'(got.ch), 0);
                end
                else
                begin
                    want = codec_out_q.pop_front();
                    if (got.ch !== want.ch)
                        report_mismatch("out_byte", int'(got.ch), int'(want.ch));
                    if (got.last !== want.last)
                        report_mismatch("out_last", int'(got.last), int'(want.last));
                    if (got.err !== want.err)
                        report_mismatch("error", int'(got.err), int'(want.err));
                end
                results_seen++;
            end
            if (cfg_wr_en)
            begin
                cur_mode = cfg_wr_data;
                clear_group();
            end
            if (s_tvalid && s_tready)
            begin
                codec_step(s_tdata, s_tlast);
                items_seen++;
            end
        end
    end

    // driver: bursts of items with random gaps; hold an item until accepted
    always @(negedge clk)
    begin : driver
        feed_t      item;
        logic       nv;
        logic [7:0] nd;
        logic       nl;
        nv = s_tvalid;
        nd = s_tdata;
        nl = s_tlast;
        if (rst_n && (!s_tvalid || s_fire))
        begin
            nv = 1'b0;
            if (gap_left > 0)
            begin
                gap_left--;
            end
            else if (byte_feed_q.size() != 0)
            begin
                item = byte_feed_q.pop_front();
                nv = 1'b1;
                nd = item.data;
                nl = item.last;
                if (burst_left > 0)
                begin
                    burst_left--;
                end
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
        end
        s_tvalid <= nv;
        s_tdata  <= nd;
        s_tlast  <= nl;
    end

    // receiver: stall on a random 16-bit ready pattern that is redrawn each time rx_tick wraps
    always @(negedge clk)
    begin : receiver
        logic [15:0] pat;
        pat = rx_pat;
        if (rx_tick == 6'd0)
        begin
            case ($urandom_range(0, 3))
                0:       pat = 16'hffff;
                1:       pat = 16'($urandom_range(0, 65535)) | 16'h0001;
                2:       pat = 16'h5555;
                default: pat = 16'($urandom_range(0, 65535) & $urandom_range(0, 65535)) | 16'h0001;
            endcase
        end
        rx_pat   <= pat;
        rx_tick  <= rx_tick + 6'd1;
        m_tready <= pat[rx_tick[3:0]];
    end

    always @(posedge clk)
    begin
        cycle_cnt = cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic push_item(input logic [7:0] d, input logic lst);
        feed_t item;
        item.data = d;
        item.last = lst;
        byte_feed_q.push_back(item);
    endtask

    task automatic wait_drained();
        while (byte_feed_q.size() != 0 || s_tvalid || codec_out_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_mode(input logic m);
        wait_drained();
        repeat (SETTLE) @(posedge clk);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        mode_writes++;
    endtask

    task automatic queue_stream(input logic m, input int len, input bit close, input bit noisy,
                                input int pause_at);
        logic [7:0] d;
        for (int i = 0; i < len; i++)
        begin
            if (i == pause_at)
                wait_drained();
            if (m == b85_pkg::MODE_ENC || noisy)
                d = 8'($urandom_range(0, 255));
            else
                d = b85_char($urandom_range(0, 84));
            push_item(d, close && (i == len - 1));
        end
        rnd_items += len;
    endtask

    initial
    begin : stimulus
        logic phase_mode;
        bit   noisy;
        bit   paused_once;
        int   n;
        int   len;
        int   pause;
        paused_once = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // encode: single byte, all-ones word closing with last, zero group then short tail
        write_mode(b85_pkg::MODE_ENC);
        push_item(8'h00, 1'b1);
        push_item(8'hff, 1'b0);
        push_item(8'hff, 1'b0);
        push_item(8'hff, 1'b0);
        push_item(8'hff, 1'b1);
        push_item(8'h00, 1'b0);
        push_item(8'h00, 1'b0);
        push_item(8'h00, 1'b0);
        push_item(8'h00, 1'b0);
        push_item(8'h80, 1'b1);
        // abandon a partial group with a mode write
        push_item(8'h12, 1'b0);
        push_item(8'h34, 1'b0);
        write_mode(b85_pkg::MODE_DEC);

        // decode: alphabet edges, backslash and out-of-alphabet bytes, short final group
        push_item(8'h23, 1'b0);
        push_item(8'h5b, 1'b0);
        push_item(8'h5d, 1'b0);
        push_item(8'h78, 1'b0);
        push_item(8'h78, 1'b0);
        push_item(8'h5c, 1'b0);
        push_item(8'h00, 1'b0);
        push_item(8'hff, 1'b0);
        push_item(8'h01, 1'b0);
        push_item(8'h80, 1'b1);
        push_item(8'h41, 1'b0);
        push_item(8'h42, 1'b1);
        push_item(8'h30, 1'b0);
        push_item(8'h31, 1'b0);
        streams += 6;
        rnd_items = 0;

        while (rnd_items < RAND_ITEMS)
        begin
            phase_mode = 1'($urandom_range(0, 1));
            write_mode(phase_mode);
            n = $urandom_range(1, 5);
            for (int s = 0; s < n; s++)
            begin
                noisy = ($urandom_range(0, 5) == 0);
                if (phase_mode == b85_pkg::MODE_DEC && $urandom_range(0, 4) != 0)
                    len = 5 * $urandom_range(1, 6);
                else if ($urandom_range(0, 7) == 0)
                    len = $urandom_range(13, 40);
                else
                    len = $urandom_range(1, 12);
                pause = -1;
                if (len >= 2 && (!paused_once || $urandom_range(0, 19) == 0))
                begin
                    pause = len / 2;
                    paused_once = 1'b1;
                end
                queue_stream(phase_mode, len, 1'b1, noisy, pause);
                streams++;
            end
            if ($urandom_range(0, 3) == 0)
                queue_stream(phase_mode, $urandom_range(1, 3), 1'b0, 1'b0, -1);
        end

        wait_drained();
        repeat (2 * SETTLE) @(posedge clk);
        if (codec_out_q.size() != 0)
            report_mismatch("items never produced, count", 0, codec_out_q.size());
        $display("covered %0d input items in %0d streams over %0d mode writes",
                 items_seen, streams, mode_writes);
        $display("checked %0d output items in %0d cycles, %0d mismatches",
                 results_seen, cycle_cnt, fail_cnt);
        if (fail_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
